/* hdl/dcmr_pkg.sv */
// ----------------------------------------------------------------------------
// dcmr_pkg: shared constants and types of the depthwise convolution MAC
// Widths of the lane words, accumulator format, register indexes and the
// activation control group passed from the top level to the merge stage.
// ----------------------------------------------------------------------------
package dcmr_pkg;

  localparam int unsigned LANES         = 8;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned PROD_W        = 2 * SAMPLE_W;
  localparam int unsigned ACC_W         = 40;
  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned LANE_GROUP_W  = LANES * SAMPLE_W;
  localparam int unsigned IN_DATA_W     = 3 * LANE_GROUP_W;
  localparam int unsigned OUT_DATA_W    = LANE_GROUP_W;

  localparam int unsigned OUT_DEPTH     = 4;

  localparam int unsigned CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU_ON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELU6_ON = CFG_IDX_W'(1);

  typedef struct packed {
    logic relu_on;
    logic relu6_on;
  } act_cfg_t;

endpackage

/* hdl/dcmr_lane.sv */
// ----------------------------------------------------------------------------
// dcmr_lane: one multiply-accumulate lane
// Registers sample times weight, then loads or adds into a saturating
// 40-bit accumulator. One word per cycle.
// ----------------------------------------------------------------------------
module dcmr_lane #(
  parameter int unsigned FRAC_BITS = dcmr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               first_i,
  input  logic signed [dcmr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [dcmr_pkg::SAMPLE_W-1:0] weight_i,
  input  logic signed [dcmr_pkg::SAMPLE_W-1:0] bias_i,
  output logic signed [dcmr_pkg::ACC_W-1:0]    acc_o
);
  import dcmr_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic                     valid_q;
  logic                     first_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  bias_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W:0]    sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      valid_q <= valid_i;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      first_q <= first_i;
      prod_q  <= PROD_W'(sample_i * weight_i);
      bias_q  <= ACC_W'(bias_i) <<< FRAC_BITS;
    end
  end

  // The bias lands on the accumulator's binary point, which sits at
  // twice the fraction width of the operands.
  always_comb begin
    base = first_q ? bias_q : acc_q;
    sum  = (ACC_W+1)'(base) + (ACC_W+1)'(prod_q);
    if (!valid_q) begin
      acc_d = acc_q;
    end else if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_d = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  assign acc_o = acc_q;

endmodule

/* hdl/dcmr_merge.sv */
// ----------------------------------------------------------------------------
// dcmr_merge: activation and result queue
// Scales, saturates and clamps all lane accumulators, packs them into one
// result word and holds finished words in a small queue for the output.
// ----------------------------------------------------------------------------
module dcmr_merge #(
  parameter int unsigned FRAC_BITS = dcmr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dcmr_pkg::act_cfg_t                  cfg_i,
  input  logic signed [dcmr_pkg::ACC_W-1:0]   acc_i [dcmr_pkg::LANES],
  input  logic                                push_i,
  input  logic [1:0]                          pend_i,
  output logic                                space_o,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [dcmr_pkg::OUT_DATA_W-1:0]     data_o
);
  import dcmr_pkg::*;

  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned HI_W  = ACC_W - SAMPLE_W + 1;
  localparam logic signed [SAMPLE_W-1:0] SIX    = SAMPLE_W'(6 << FRAC_BITS);
  localparam logic signed [SAMPLE_W-1:0] RES_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] RES_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [ACC_W-1:0]    shifted [LANES];
  logic signed [SAMPLE_W-1:0] lane_res [LANES];
  logic [HI_W-1:0]            hi_bits [LANES];
  logic [OUT_DATA_W-1:0]      packed_res;

  logic [OUT_DATA_W-1:0] mem_q [OUT_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  pop;

  // Floor shift, saturation to 16 bits, then the enabled clamps.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shifted[l] = acc_i[l] >>> FRAC_BITS;
      hi_bits[l] = shifted[l][ACC_W-1:SAMPLE_W-1];
      if ((&hi_bits[l]) || !(|hi_bits[l])) begin
        lane_res[l] = shifted[l][SAMPLE_W-1:0];
      end else begin
        lane_res[l] = shifted[l][ACC_W-1] ? RES_MIN : RES_MAX;
      end
      if ((cfg_i.relu_on || cfg_i.relu6_on) && lane_res[l] < 0) begin
        lane_res[l] = '0;
      end
      if (cfg_i.relu6_on && lane_res[l] > SIX) begin
        lane_res[l] = SIX;
      end
      packed_res[l*SAMPLE_W +: SAMPLE_W] = lane_res[l];
    end
  end

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign space_o = ((CNT_W+1)'(count_q) + (CNT_W+1)'(pend_i)) < (CNT_W+1)'(OUT_DEPTH);

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= packed_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CNT_W'(OUT_DEPTH)) || pop)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(OUT_DEPTH))
    else $error("result queue count out of range");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("result queue count did not drop on pop");

  a_space_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    space_o |-> ((CNT_W+1)'(count_q) + (CNT_W+1)'(pend_i)) < (CNT_W+1)'(OUT_DEPTH))
    else $error("input taken without room for its result");

endmodule

/* hdl/depthwise_conv_mac_relu.sv */
// ----------------------------------------------------------------------------
// depthwise_conv_mac_relu: eight-lane depthwise convolution MAC with ReLU6
// Top level: configuration registers, lane array, tap flag pipeline and the
// merge stage with its result queue.
// ----------------------------------------------------------------------------
// Each input word is one kernel tap for eight channels; the block takes one
// word per clock cycle indefinitely as long as results are drained. A word
// with tuser (first tap) set reloads every lane's accumulator with its bias
// plus the product, other words add their product, and a word with tlast
// (last tap) set produces one result word once it is accepted and has gone
// through the registered multiplier, the saturating 40-bit accumulate, and
// finally the shift, saturate and clamp on the way into the output
// queue. The output queue holds four result words; s_axis_tready falls only
// when the words waiting there plus those still in the pipeline would fill
// it, so a stalled consumer throttles the input without a combinational path
// from m_axis_tready. Accumulators are not cleared when a result leaves; a
// tap with neither flag after a window keeps adding to them. The activation
// registers must be written only while the block is idle.
// ----------------------------------------------------------------------------
module depthwise_conv_mac_relu #(
  parameter int unsigned FRAC_BITS = dcmr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata, lowest bit first: sample_lanes_lo, sample_lanes_hi,
  // weight_lanes_lo, weight_lanes_hi, bias_lanes_lo, bias_lanes_hi
  input  logic [dcmr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: first_tap
  input  logic                               s_axis_tuser,
  // tlast: last_tap
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit first: result_lanes_lo, result_lanes_hi
  output logic [dcmr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dcmr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic                               cfg_data_i
);
  import dcmr_pkg::*;

  logic                    accept;
  logic                    last1_q;
  logic                    res_v_q;
  logic [1:0]              pend;
  logic                    space;
  act_cfg_t                cfg_q;
  logic signed [ACC_W-1:0] lane_acc [LANES];

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RELU_ON:  cfg_q.relu_on  <= cfg_data_i;
        CFG_RELU6_ON: cfg_q.relu6_on <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = space;

  // The last-tap flag travels alongside the lanes: stage one holds the
  // product, stage two the updated accumulator that the merge then reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last1_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      last1_q <= accept && s_axis_tlast;
      res_v_q <= last1_q;
    end
  end

  // Results already committed but not yet in the queue.
  assign pend = {1'b0, last1_q} + {1'b0, res_v_q};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dcmr_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (accept),
      .first_i  (s_axis_tuser),
      .sample_i (s_axis_tdata[l*SAMPLE_W +: SAMPLE_W]),
      .weight_i (s_axis_tdata[LANE_GROUP_W + l*SAMPLE_W +: SAMPLE_W]),
      .bias_i   (s_axis_tdata[2*LANE_GROUP_W + l*SAMPLE_W +: SAMPLE_W]),
      .acc_o    (lane_acc[l])
    );
  end

  dcmr_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .acc_i   (lane_acc),
    .push_i  (res_v_q),
    .pend_i  (pend),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule
